// ===== sv/scc_counter_top_macros.svh =====
// Assertion macros shared by the scc_counter RTL.
// Included by the modules that carry concurrent checks; needs no other file.
`ifndef SCC_COUNTER_TOP_MACROS_SVH
`define SCC_COUNTER_TOP_MACROS_SVH

// Same-cycle implication, silenced while reset is high
`define SCC_ASSERT_IMP(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("scc_counter: same-cycle check failed");

// Next-cycle implication, silenced while reset is high
`define SCC_ASSERT_NXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("scc_counter: next-cycle check failed");

`endif

// ===== sv/scc_pkg.sv =====
// Shared constants, codes and controller/datapath command and status structs.
// No dependencies; compile first.
`default_nettype none

package scc_pkg;

   // Fixed field widths of the channels and the register
   localparam int CFG_W     = 11;
   localparam int FUNC_W    = 1;
   localparam int NODE_IN_W = 10;
   localparam int COUNT_W   = 11;

   // Default capacities
   localparam int DEF_MAX_NODES = 1024;
   localparam int DEF_MAX_EDGES = 4096;

   // Request function codes
   localparam logic [FUNC_W-1:0] FUNC_ADD   = 1'b0;
   localparam logic [FUNC_W-1:0] FUNC_COUNT = 1'b1;

   localparam logic [CFG_W-1:0] NODE_COUNT_RST = 11'd1;

   // Controller to datapath
   typedef struct packed {
      logic accept;       // capture request, read list heads
      logic add_commit;   // store edge or flag drop
      logic clr_step;     // clear one node entry, advance sweep
      logic clr_heads;    // sweep also nulls list heads
      logic clr_done;     // empty the edge store and drop flag
      logic count_init;   // forward pass, zero root/finish/count
      logic set_rev;      // switch to reverse pass
      logic root_read;    // w = root, read its mark
      logic root_next;    // advance root
      logic mark_w;       // mark w visited, read heads of w
      logic sp_zero;      // empty stack for a new walk
      logic stack_write;  // spill current top below the new one
      logic head_load;    // top = (w, head of w), grow stack
      logic step_fin;     // record finished node
      logic pop_load;     // top = entry below, shrink stack
      logic edge_load;    // follow edge: advance top link, w = other end
      logic fin_read;     // step back through finish order
      logic fin_load;     // w = finished node, read its mark
      logic count_inc;    // one more component
      logic result_load;  // load result register
   } ctl_cmd_type;

   // Datapath to controller
   typedef struct packed {
      logic req_count;
      logic clr_last;
      logic root_done;
      logic vis_rd;
      logic edge_nil;
      logic sp_one;
      logic sp_full;
      logic w_ok;
      logic fin_zero;
      logic rsp_busy;
      logic rev;
   } ctl_sts_type;

endpackage

`default_nettype wire

// ===== sv/scc_if.sv =====
// Valid/ready channel interfaces for requests and responses.
// Depends on scc_pkg for the payload widths.
`default_nettype none

interface scc_req_if import scc_pkg::*; ();
   logic                 valid;
   logic                 ready;
   logic [FUNC_W-1:0]    func;
   logic [NODE_IN_W-1:0] from_node;
   logic [NODE_IN_W-1:0] to_node;

   modport source (output valid, func, from_node, to_node, input ready);
   modport sink   (input valid, func, from_node, to_node, output ready);
endinterface

interface scc_rsp_if import scc_pkg::*; ();
   logic               valid;
   logic               ready;
   logic [COUNT_W-1:0] component_count;
   logic               edges_dropped;

   modport source (output valid, component_count, edges_dropped, input ready);
   modport sink   (input valid, component_count, edges_dropped, output ready);
endinterface

`default_nettype wire

// ===== sv/scc_ctrl.sv =====
// Sequencer for edge loading, the two depth-first passes and the clear sweeps.
// Depends on scc_pkg; drives the datapath through ctl_cmd_type.
`default_nettype none

module scc_ctrl import scc_pkg::*; (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_valid,
   output logic             req_ready,
   input  wire ctl_sts_type sts,
   output ctl_cmd_type      cmd
);

   localparam logic [3:0] S_CLEAR     = 4'd0;
   localparam logic [3:0] S_IDLE      = 4'd1;
   localparam logic [3:0] S_ADD       = 4'd2;
   localparam logic [3:0] S_ROOT_CHK  = 4'd3;
   localparam logic [3:0] S_ROOT_WAIT = 4'd4;
   localparam logic [3:0] S_HEAD_WAIT = 4'd5;
   localparam logic [3:0] S_STEP      = 4'd6;
   localparam logic [3:0] S_POP_WAIT  = 4'd7;
   localparam logic [3:0] S_EDGE_WAIT = 4'd8;
   localparam logic [3:0] S_VIS_WAIT  = 4'd9;
   localparam logic [3:0] S_CLR_VIS   = 4'd10;
   localparam logic [3:0] S_FIN_CHK   = 4'd11;
   localparam logic [3:0] S_FIN_WAIT  = 4'd12;
   localparam logic [3:0] S_FIN_VIS   = 4'd13;
   localparam logic [3:0] S_RESULT    = 4'd14;

   logic [3:0] state_ff;
   logic [3:0] state_in;

   // Next state and commands
   always_comb begin
      state_in  = state_ff;
      cmd       = '0;
      req_ready = 1'b0;
      case (state_ff)
         S_CLEAR: begin
            cmd.clr_step  = 1'b1;
            cmd.clr_heads = 1'b1;
            if (sts.clr_last) begin
               cmd.clr_done = 1'b1;
               state_in     = S_IDLE;
            end
         end
         S_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd.accept = 1'b1;
               if (sts.req_count) begin
                  cmd.count_init = 1'b1;
                  state_in       = S_ROOT_CHK;
               end else begin
                  state_in = S_ADD;
               end
            end
         end
         S_ADD: begin
            cmd.add_commit = 1'b1;
            state_in       = S_IDLE;
         end
         S_ROOT_CHK: begin
            if (sts.root_done) begin
               state_in = S_CLR_VIS;
            end else begin
               cmd.root_read = 1'b1;
               state_in      = S_ROOT_WAIT;
            end
         end
         S_ROOT_WAIT: begin
            if (sts.vis_rd) begin
               cmd.root_next = 1'b1;
               state_in      = S_ROOT_CHK;
            end else begin
               cmd.mark_w  = 1'b1;
               cmd.sp_zero = 1'b1;
               state_in    = S_HEAD_WAIT;
            end
         end
         S_HEAD_WAIT: begin
            cmd.head_load = 1'b1;
            state_in      = S_STEP;
         end
         S_STEP: begin
            if (sts.edge_nil) begin
               cmd.step_fin = 1'b1;
               if (!sts.sp_one) begin
                  state_in = S_POP_WAIT;
               end else if (sts.rev) begin
                  state_in = S_FIN_CHK;
               end else begin
                  cmd.root_next = 1'b1;
                  state_in      = S_ROOT_CHK;
               end
            end else begin
               state_in = S_EDGE_WAIT;
            end
         end
         S_POP_WAIT: begin
            cmd.pop_load = 1'b1;
            state_in     = S_STEP;
         end
         S_EDGE_WAIT: begin
            cmd.edge_load = 1'b1;
            state_in      = S_VIS_WAIT;
         end
         S_VIS_WAIT: begin
            if (sts.w_ok && !sts.vis_rd && !sts.sp_full) begin
               cmd.mark_w      = 1'b1;
               cmd.stack_write = 1'b1;
               state_in        = S_HEAD_WAIT;
            end else begin
               state_in = S_STEP;
            end
         end
         S_CLR_VIS: begin
            cmd.clr_step = 1'b1;
            if (sts.clr_last) begin
               cmd.set_rev = 1'b1;
               state_in    = S_FIN_CHK;
            end
         end
         S_FIN_CHK: begin
            if (sts.fin_zero) begin
               state_in = S_RESULT;
            end else begin
               cmd.fin_read = 1'b1;
               state_in     = S_FIN_WAIT;
            end
         end
         S_FIN_WAIT: begin
            cmd.fin_load = 1'b1;
            state_in     = S_FIN_VIS;
         end
         S_FIN_VIS: begin
            if (sts.w_ok && !sts.vis_rd) begin
               cmd.count_inc = 1'b1;
               cmd.mark_w    = 1'b1;
               cmd.sp_zero   = 1'b1;
               state_in      = S_HEAD_WAIT;
            end else begin
               state_in = S_FIN_CHK;
            end
         end
         S_RESULT: begin
            if (!sts.rsp_busy) begin
               cmd.result_load = 1'b1;
               state_in        = S_CLEAR;
            end
         end
         default: begin
            state_in = S_CLEAR;
         end
      endcase
   end

   // State register; reset starts the clearing sweep
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_CLEAR;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

`default_nettype wire

// ===== sv/scc_dpath.sv =====
// Datapath: graph store, visited marks, finish order, walk stack, result register.
// Depends on scc_pkg and scc_counter_top_macros.svh; steered by scc_ctrl.
`default_nettype none
`include "scc_counter_top_macros.svh"

module scc_dpath import scc_pkg::*; #(
   parameter int MAX_NODES = DEF_MAX_NODES,
   parameter int MAX_EDGES = DEF_MAX_EDGES
) (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 csr_we,
   input  wire logic [CFG_W-1:0]     csr_wdata,
   input  wire logic [FUNC_W-1:0]    req_func,
   input  wire logic [NODE_IN_W-1:0] req_from_node,
   input  wire logic [NODE_IN_W-1:0] req_to_node,
   output logic                      rsp_valid,
   input  wire logic                 rsp_ready,
   output logic [COUNT_W-1:0]        rsp_component_count,
   output logic                      rsp_edges_dropped,
   input  wire ctl_cmd_type          cmd,
   output ctl_sts_type               sts
);

   localparam int NW  = $clog2(MAX_NODES);
   localparam int CW  = $clog2(MAX_NODES + 1);
   localparam int AW  = (CW > CFG_W) ? CW : CFG_W;
   localparam int EW  = $clog2(MAX_EDGES + 1);
   localparam int EAW = (MAX_EDGES > 1) ? $clog2(MAX_EDGES) : 1;
   localparam logic [EW-1:0] NIL_EDGE = EW'(MAX_EDGES);

   // Memories
   logic [EW-1:0] fhead_mem [MAX_NODES];
   logic [EW-1:0] rhead_mem [MAX_NODES];
   logic [NW-1:0] esrc_mem  [MAX_EDGES];
   logic [NW-1:0] etgt_mem  [MAX_EDGES];
   logic [EW-1:0] fnext_mem [MAX_EDGES];
   logic [EW-1:0] rnext_mem [MAX_EDGES];
   logic          vis_mem   [MAX_NODES];
   logic [NW-1:0] fin_mem   [MAX_NODES];
   logic [NW-1:0] stkn_mem  [MAX_NODES];
   logic [EW-1:0] stke_mem  [MAX_NODES];

   // Registered read data
   logic [EW-1:0] fhead_rd_ff, rhead_rd_ff, fnext_rd_ff, rnext_rd_ff, stke_rd_ff;
   logic [NW-1:0] esrc_rd_ff, etgt_rd_ff, fin_rd_ff, stkn_rd_ff;
   logic          vis_rd_ff;

   // Control and payload registers
   logic [CFG_W-1:0]     node_count_ff;
   logic [NODE_IN_W-1:0] from_ff, to_ff;
   logic [EW-1:0]        edges_ff;
   logic                 dropped_ff;
   logic                 rev_ff;
   logic [CW-1:0]        root_ff, sp_ff, fin_ff, count_ff;
   logic [NW-1:0]        w_ff, top_node_ff, clr_ff;
   logic [EW-1:0]        top_edge_ff;
   logic                 rsp_valid_ff;
   logic [COUNT_W-1:0]   rsp_count_ff;
   logic                 rsp_drop_ff;

   logic [AW-1:0] nc_ext, n_eff;
   logic          edge_ok, fin_room;
   logic [NW-1:0] from_idx, to_idx, edge_w, vis_addr, head_fa, head_ra;
   logic [NW-1:0] sp_top_idx, sp_below_idx, fin_prev_idx;
   logic [EAW-1:0] edge_idx, store_idx;

   // Nodes in use, saturated to capacity
   assign nc_ext = AW'(node_count_ff);
   assign n_eff  = (nc_ext > AW'(MAX_NODES)) ? AW'(MAX_NODES) : nc_ext;

   assign from_idx     = NW'(from_ff);
   assign to_idx       = NW'(to_ff);
   assign edge_ok      = (AW'(from_ff) < n_eff) && (AW'(to_ff) < n_eff) && (edges_ff != NIL_EDGE);
   assign fin_room     = fin_ff < CW'(MAX_NODES);
   assign edge_w       = rev_ff ? esrc_rd_ff : etgt_rd_ff;
   assign edge_idx     = top_edge_ff[EAW-1:0];
   assign store_idx    = edges_ff[EAW-1:0];
   assign sp_top_idx   = NW'(sp_ff - 1'b1);
   assign sp_below_idx = NW'(sp_ff - 2'd2);
   assign fin_prev_idx = NW'(fin_ff - 1'b1);
   assign head_fa      = cmd.accept ? NW'(req_from_node) : w_ff;
   assign head_ra      = cmd.accept ? NW'(req_to_node) : w_ff;

   // Visited read address: root probe, edge end or finished node
   always_comb begin
      if (cmd.root_read) begin
         vis_addr = NW'(root_ff);
      end else if (cmd.edge_load) begin
         vis_addr = edge_w;
      end else if (cmd.fin_load) begin
         vis_addr = fin_rd_ff;
      end else begin
         vis_addr = w_ff;
      end
   end

   // List heads: add link, sweep to null, read for add or walk
   always_ff @(posedge clock) begin
      if (cmd.add_commit && edge_ok) begin
         fhead_mem[from_idx] <= edges_ff;
         rhead_mem[to_idx]   <= edges_ff;
      end else if (cmd.clr_step && cmd.clr_heads) begin
         fhead_mem[clr_ff] <= NIL_EDGE;
         rhead_mem[clr_ff] <= NIL_EDGE;
      end
      fhead_rd_ff <= fhead_mem[head_fa];
      rhead_rd_ff <= rhead_mem[head_ra];
   end

   // Edge store
   always_ff @(posedge clock) begin
      if (cmd.add_commit && edge_ok) begin
         esrc_mem[store_idx]  <= from_idx;
         etgt_mem[store_idx]  <= to_idx;
         fnext_mem[store_idx] <= fhead_rd_ff;
         rnext_mem[store_idx] <= rhead_rd_ff;
      end
      esrc_rd_ff  <= esrc_mem[edge_idx];
      etgt_rd_ff  <= etgt_mem[edge_idx];
      fnext_rd_ff <= fnext_mem[edge_idx];
      rnext_rd_ff <= rnext_mem[edge_idx];
   end

   // Visited marks
   always_ff @(posedge clock) begin
      if (cmd.clr_step) begin
         vis_mem[clr_ff] <= 1'b0;
      end else if (cmd.mark_w) begin
         vis_mem[w_ff] <= 1'b1;
      end
      vis_rd_ff <= vis_mem[vis_addr];
   end

   // Finish order
   always_ff @(posedge clock) begin
      if (cmd.step_fin && !rev_ff && fin_room) begin
         fin_mem[NW'(fin_ff)] <= top_node_ff;
      end
      fin_rd_ff <= fin_mem[fin_prev_idx];
   end

   // Walk stack below the cached top entry
   always_ff @(posedge clock) begin
      if (cmd.stack_write) begin
         stkn_mem[sp_top_idx] <= top_node_ff;
         stke_mem[sp_top_idx] <= top_edge_ff;
      end
      stkn_rd_ff <= stkn_mem[sp_below_idx];
      stke_rd_ff <= stke_mem[sp_below_idx];
   end

   // Configuration register
   always_ff @(posedge clock) begin
      if (reset) begin
         node_count_ff <= NODE_COUNT_RST;
      end else if (csr_we) begin
         node_count_ff <= csr_wdata;
      end
   end

   // Request capture
   always_ff @(posedge clock) begin
      if (cmd.accept) begin
         from_ff <= req_from_node;
         to_ff   <= req_to_node;
      end
   end

   // Store fill and drop flag
   always_ff @(posedge clock) begin
      if (reset || cmd.clr_done) begin
         edges_ff   <= '0;
         dropped_ff <= 1'b0;
      end else if (cmd.add_commit) begin
         if (edge_ok) begin
            edges_ff <= edges_ff + 1'b1;
         end else begin
            dropped_ff <= 1'b1;
         end
      end
   end

   // Clear sweep counter
   always_ff @(posedge clock) begin
      if (reset) begin
         clr_ff <= '0;
      end else if (cmd.clr_step) begin
         clr_ff <= (clr_ff == NW'(MAX_NODES - 1)) ? '0 : clr_ff + 1'b1;
      end
   end

   // Walk control: pass, root, stack pointer, finish index, count
   always_ff @(posedge clock) begin
      if (reset) begin
         rev_ff   <= 1'b0;
         root_ff  <= '0;
         sp_ff    <= '0;
         fin_ff   <= '0;
         count_ff <= '0;
      end else begin
         if (cmd.count_init) begin
            rev_ff   <= 1'b0;
            root_ff  <= '0;
            fin_ff   <= '0;
            count_ff <= '0;
         end
         if (cmd.set_rev) begin
            rev_ff <= 1'b1;
         end
         if (cmd.root_next) begin
            root_ff <= root_ff + 1'b1;
         end
         if (cmd.sp_zero) begin
            sp_ff <= '0;
         end else if (cmd.head_load) begin
            sp_ff <= sp_ff + 1'b1;
         end else if (cmd.pop_load) begin
            sp_ff <= sp_ff - 1'b1;
         end
         if (cmd.step_fin && !rev_ff && fin_room) begin
            fin_ff <= fin_ff + 1'b1;
         end else if (cmd.fin_read) begin
            fin_ff <= fin_ff - 1'b1;
         end
         if (cmd.count_inc) begin
            count_ff <= count_ff + 1'b1;
         end
      end
   end

   // Current node and top of stack
   always_ff @(posedge clock) begin
      if (cmd.root_read) begin
         w_ff <= NW'(root_ff);
      end else if (cmd.edge_load) begin
         w_ff <= edge_w;
      end else if (cmd.fin_load) begin
         w_ff <= fin_rd_ff;
      end
      if (cmd.head_load) begin
         top_node_ff <= w_ff;
         top_edge_ff <= rev_ff ? rhead_rd_ff : fhead_rd_ff;
      end else if (cmd.pop_load) begin
         top_node_ff <= stkn_rd_ff;
         top_edge_ff <= stke_rd_ff;
      end else if (cmd.edge_load) begin
         top_edge_ff <= rev_ff ? rnext_rd_ff : fnext_rd_ff;
      end
   end

   // Result register; hold until transfer
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (cmd.result_load) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.result_load) begin
         rsp_count_ff <= COUNT_W'(count_ff);
         rsp_drop_ff  <= dropped_ff;
      end
   end

   assign rsp_valid           = rsp_valid_ff;
   assign rsp_component_count = rsp_count_ff;
   assign rsp_edges_dropped   = rsp_drop_ff;

   // Status to the controller
   always_comb begin
      sts.req_count = (req_func == FUNC_COUNT);
      sts.clr_last  = (clr_ff == NW'(MAX_NODES - 1));
      sts.root_done = (AW'(root_ff) >= n_eff);
      sts.vis_rd    = vis_rd_ff;
      sts.edge_nil  = (top_edge_ff == NIL_EDGE);
      sts.sp_one    = (sp_ff == CW'(1));
      sts.sp_full   = (sp_ff >= CW'(MAX_NODES));
      sts.w_ok      = (AW'(w_ff) < n_eff);
      sts.fin_zero  = (fin_ff == '0);
      sts.rsp_busy  = rsp_valid_ff;
      sts.rev       = rev_ff;
   end

   `SCC_ASSERT_IMP(a_push_room, clock, reset, cmd.stack_write, (sp_ff != '0) && (sp_ff < CW'(MAX_NODES)))
   `SCC_ASSERT_NXT(a_store_adv, clock, reset, cmd.add_commit && edge_ok, edges_ff == $past(edges_ff) + 1'b1)
   `SCC_ASSERT_IMP(a_rsp_free, clock, reset, cmd.result_load, !rsp_valid_ff)
   `SCC_ASSERT_IMP(a_count_rev, clock, reset, cmd.count_inc, rev_ff)

endmodule

`default_nettype wire

// ===== sv/scc_counter_top.sv =====
// Strongly connected component counter (two-pass depth-first method).
// Request channel: func 0 adds a directed edge from_node -> to_node, func 1
//   counts the components among nodes 0..node_count-1 and empties the graph.
// Response channel: one transfer per count item (component_count,
//   edges_dropped); edge items give no response.
// csr_we/csr_wdata write node_count; write only while the block is idle.
// A count item runs the forward pass, a sweep that clears the visited marks,
//   the reverse pass (every node in use is walked in both passes) and a sweep
//   that nulls the list heads and visited marks; each pass walks the edge lists.
// After reset a sweep over all MAX_NODES node entries nulls the list heads; ready
//   is low until it ends. The same sweep runs after each count.
// The result waits in an output register: further edge items are accepted
//   while the receiver stalls, and a later count waits only at its end.
// Depends on scc_pkg, scc_if, scc_ctrl and scc_dpath.
`default_nettype none

module scc_counter_top import scc_pkg::*; #(
   parameter int MAX_NODES = DEF_MAX_NODES,
   parameter int MAX_EDGES = DEF_MAX_EDGES
) (
   input  wire logic             clock,
   input  wire logic             reset,
   scc_req_if.sink               req_bus,
   scc_rsp_if.source             rsp_bus,
   input  wire logic             csr_we,
   input  wire logic [CFG_W-1:0] csr_wdata
);

   ctl_cmd_type cmd;
   ctl_sts_type sts;
   logic        req_ready;

   assign req_bus.ready = req_ready;

   // Sequencer
   scc_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_bus.valid),
      .req_ready (req_ready),
      .sts       (sts),
      .cmd       (cmd)
   );

   // Graph store and walk datapath
   scc_dpath #(
      .MAX_NODES (MAX_NODES),
      .MAX_EDGES (MAX_EDGES)
   ) u_dpath (
      .clock               (clock),
      .reset               (reset),
      .csr_we              (csr_we),
      .csr_wdata           (csr_wdata),
      .req_func            (req_bus.func),
      .req_from_node       (req_bus.from_node),
      .req_to_node         (req_bus.to_node),
      .rsp_valid           (rsp_bus.valid),
      .rsp_ready           (rsp_bus.ready),
      .rsp_component_count (rsp_bus.component_count),
      .rsp_edges_dropped   (rsp_bus.edges_dropped),
      .cmd                 (cmd),
      .sts                 (sts)
   );

endmodule

`default_nettype wire

// ===== tb/scc_tb_if.sv =====
// Testbench package: the stimulus row type used by the directed table.
// Depends on scc_pkg for the field widths and function codes.
`timescale 1ns / 1ps
`default_nettype none

package scc_tb_pkg;
   import scc_pkg::*;

   // One row of stimulus: an edge or a count, with optional typed-in expectation
   typedef struct {
      logic [FUNC_W-1:0]    func;
      logic [NODE_IN_W-1:0] from_node;
      logic [NODE_IN_W-1:0] to_node;
      bit                   has_fixed;
      int                   fixed_count;
      bit                   fixed_dropped;
   } stim_row_type;
endpackage

`default_nettype wire

// ===== tb/testbench.sv =====
// Self-checking bench for scc_counter_top: directed table, then random graphs,
// checked against a component-count predictor. Depends on scc_pkg, scc_if, scc_tb_pkg.
`timescale 1ns / 1ps
`default_nettype none

module testbench import scc_pkg::*, scc_tb_pkg::*; ();

   localparam int NMAX = DEF_MAX_NODES;
   localparam int EMAX = DEF_MAX_EDGES;
   localparam int NIL  = EMAX;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic csr_we = 1'b0;
   logic [CFG_W-1:0] csr_wdata = '0;

   scc_req_if req_bus ();
   scc_rsp_if rsp_bus ();

   scc_counter_top dut (
      .clock(clock), .reset(reset), .req_bus(req_bus), .rsp_bus(rsp_bus),
      .csr_we(csr_we), .csr_wdata(csr_wdata)
   );

   always #5 clock = ~clock;

   // Predictor state
   int unsigned nodes_cfg;
   int fwd_head[NMAX];
   int rev_head[NMAX];
   int e_src[EMAX];
   int e_dst[EMAX];
   int fwd_nxt[EMAX];
   int rev_nxt[EMAX];
   bit seen[NMAX];
   int fin_list[NMAX];
   int stk_node[NMAX];
   int stk_edge[NMAX];
   int n_edges;
   bit lost_edge;

   typedef struct {
      int count;
      bit dropped;
   } scc_result_type;
   scc_result_type pending_results[$];

   int  errors = 0;
   int  results_seen = 0;
   int  counts_sent = 0;
   int  edges_sent = 0;
   int  send_idle_pct = 0;
   int  recv_stall_pct = 0;
   bit  hold_receiver = 1'b0;

   function automatic void graph_clear();
      for (int i = 0; i < NMAX; i++) begin
         fwd_head[i] = NIL;
         rev_head[i] = NIL;
         seen[i] = 1'b0;
      end
      n_edges = 0;
      lost_edge = 1'b0;
   endfunction

   function automatic int unsigned nodes_live();
      return (nodes_cfg > NMAX) ? NMAX : nodes_cfg;
   endfunction

   function automatic void edge_insert(int f, int t);
      int unsigned n;
      n = nodes_live();
      if (f >= n || t >= n || n_edges >= EMAX) begin
         lost_edge = 1'b1;
      end else begin
         e_src[n_edges] = f;
         e_dst[n_edges] = t;
         fwd_nxt[n_edges] = fwd_head[f];
         fwd_head[f] = n_edges;
         rev_nxt[n_edges] = rev_head[t];
         rev_head[t] = n_edges;
         n_edges++;
      end
   endfunction

   // Iterative depth-first walk; forward walks append to finish order
   function automatic void dfs(int root, int n, bit backward, inout int fin);
      int sp;
      int e;
      int w;
      sp = 0;
      seen[root] = 1'b1;
      stk_node[0] = root;
      stk_edge[0] = backward ? rev_head[root] : fwd_head[root];
      sp = 1;
      while (sp > 0) begin
         e = stk_edge[sp-1];
         if (e >= NIL) begin
            if (!backward && fin < NMAX) begin
               fin_list[fin] = stk_node[sp-1];
               fin++;
            end
            sp--;
         end else begin
            if (backward) begin
               stk_edge[sp-1] = rev_nxt[e];
               w = e_src[e];
            end else begin
               stk_edge[sp-1] = fwd_nxt[e];
               w = e_dst[e];
            end
            if (w < n && !seen[w] && sp < NMAX) begin
               seen[w] = 1'b1;
               stk_node[sp] = w;
               stk_edge[sp] = backward ? rev_head[w] : fwd_head[w];
               sp++;
            end
         end
      end
   endfunction

   function automatic scc_result_type components_count();
      scc_result_type r;
      int n;
      int fin;
      int v;
      n = nodes_live();
      fin = 0;
      r.count = 0;
      for (int i = 0; i < n; i++)
         if (!seen[i]) dfs(i, n, 1'b0, fin);
      for (int i = 0; i < NMAX; i++) seen[i] = 1'b0;
      while (fin > 0) begin
         fin--;
         v = fin_list[fin];
         if (v < n && !seen[v]) begin
            dfs(v, n, 1'b1, fin);
            r.count++;
         end
      end
      r.dropped = lost_edge;
      graph_clear();
      return r;
   endfunction

   // Predict an accepted request; count rows may carry a typed-in value too
   task automatic predict_request(stim_row_type row);
      scc_result_type r;
      if (row.func == FUNC_ADD) begin
         edge_insert(int'(row.from_node), int'(row.to_node));
         edges_sent++;
      end else begin
         r = components_count();
         if (row.has_fixed && (r.count != row.fixed_count || r.dropped != row.fixed_dropped)) begin
            $error("table row disagrees with predictor: count %0d/%0d dropped %0d/%0d",
                   row.fixed_count, r.count, row.fixed_dropped, r.dropped);
            errors++;
         end
         pending_results = {pending_results, r};
         counts_sent++;
      end
   endtask

   // Drive one request, hold it until the transfer, then drop valid
   task automatic send_request(stim_row_type row);
      while (send_idle_pct > 0 && $urandom_range(99) < send_idle_pct) begin
         req_bus.valid <= 1'b0;
         @(posedge clock);
      end
      req_bus.valid <= 1'b1;
      req_bus.func <= row.func;
      req_bus.from_node <= row.from_node;
      req_bus.to_node <= row.to_node;
      @(posedge clock);
      while (!req_bus.ready) @(posedge clock);
      predict_request(row);
      req_bus.valid <= 1'b0;
      @(posedge clock);
   endtask

   function automatic stim_row_type edge_row(int f, int t);
      stim_row_type r;
      r.func = FUNC_ADD;
      r.from_node = NODE_IN_W'(f);
      r.to_node = NODE_IN_W'(t);
      r.has_fixed = 1'b0;
      r.fixed_count = 0;
      r.fixed_dropped = 1'b0;
      return r;
   endfunction

   function automatic stim_row_type count_row(int c, bit d, bit fixed);
      stim_row_type r;
      r.func = FUNC_COUNT;
      r.from_node = NODE_IN_W'($urandom);
      r.to_node = NODE_IN_W'($urandom);
      r.has_fixed = fixed;
      r.fixed_count = c;
      r.fixed_dropped = d;
      return r;
   endfunction

   // Wait for all results, then let the block settle before a register write
   task automatic drain();
      while (pending_results.size() != 0) @(posedge clock);
      repeat (4 * NMAX + 50) @(posedge clock);
   endtask

   task automatic write_nodes(int unsigned v);
      csr_we <= 1'b1;
      csr_wdata <= v[CFG_W-1:0];
      @(posedge clock);
      csr_we <= 1'b0;
      nodes_cfg = v & 32'h7FF;
   endtask

   // Random graph: edges mostly inside node range, some outside, then count
   task automatic random_case(int n_items, int span);
      int f;
      int t;
      for (int k = 0; k < n_items; k++) begin
         if ($urandom_range(99) < 8) begin
            f = $urandom_range(1023);
            t = $urandom_range(1023);
         end else begin
            f = $urandom_range(span - 1);
            t = $urandom_range(span - 1);
         end
         send_request(edge_row(f, t));
      end
      send_request(count_row(0, 1'b0, 1'b0));
   endtask

   // Response readiness, with random stalls and one long hold-off
   always @(posedge clock) begin
      if (reset)
         rsp_bus.ready <= 1'b0;
      else if (hold_receiver)
         rsp_bus.ready <= 1'b0;
      else
         rsp_bus.ready <= !(recv_stall_pct > 0 && $urandom_range(99) < recv_stall_pct);
   end

   // Compare each response transfer with the oldest expectation
   always @(posedge clock) begin
      scc_result_type exp_r;
      if (!reset && rsp_bus.valid && rsp_bus.ready) begin
         results_seen++;
         if (pending_results.size() == 0) begin
            $error("response with no expectation waiting");
            errors++;
         end else begin
            exp_r = pending_results.pop_front();
            if (rsp_bus.component_count != exp_r.count) begin
               $error("component_count: expected %0d, actual %0d",
                      exp_r.count, rsp_bus.component_count);
               errors++;
            end
            if (rsp_bus.edges_dropped != exp_r.dropped) begin
               $error("edges_dropped: expected %0d, actual %0d",
                      exp_r.dropped, rsp_bus.edges_dropped);
               errors++;
            end
         end
      end
   end

   // Hard limit on run length
   initial begin
      #400ms;
      $display("run timed out");
      $display("status: fail");
      $finish;
   end

   initial begin
      stim_row_type table_rows[$];
      int phase_idle[4] = '{0, 48, 0, 19};
      int phase_stall[4] = '{0, 0, 48, 19};
      int span;
      int sz;
      req_bus.valid = 1'b0;
      req_bus.func = FUNC_ADD;
      req_bus.from_node = '0;
      req_bus.to_node = '0;
      nodes_cfg = NODE_COUNT_RST;
      graph_clear();
      repeat (10) @(posedge clock);
      reset <= 1'b0;

      // Reset value one node: a count sees a single component
      table_rows = {table_rows, count_row(1, 1'b0, 1'b1)};
      // Any edge beyond node 0 is dropped at reset width
      table_rows = {table_rows, edge_row(0, 1)};
      table_rows = {table_rows, edge_row(0, 0)};
      table_rows = {table_rows, count_row(1, 1'b1, 1'b1)};
      foreach (table_rows[i]) send_request(table_rows[i]);
      drain();

      // Node count zero: all edges dropped, count reports zero
      table_rows.delete();
      write_nodes(0);
      table_rows = {table_rows, edge_row(0, 0)};
      table_rows = {table_rows, count_row(0, 1'b1, 1'b1)};
      foreach (table_rows[i]) send_request(table_rows[i]);
      drain();

      // Full width, cycle and chain; extreme node indices
      table_rows.delete();
      write_nodes(1024);
      table_rows = {table_rows, edge_row(0, 1023)};
      table_rows = {table_rows, edge_row(1023, 0)};
      table_rows = {table_rows, edge_row(5, 6)};
      table_rows = {table_rows, edge_row(682, 341)};
      table_rows = {table_rows, edge_row(341, 682)};
      table_rows = {table_rows, count_row(1022, 1'b0, 1'b1)};
      foreach (table_rows[i]) send_request(table_rows[i]);
      drain();

      // Above capacity saturates; then lower node count after loading
      table_rows.delete();
      write_nodes(2047);
      table_rows = {table_rows, count_row(1024, 1'b0, 1'b1)};
      foreach (table_rows[i]) send_request(table_rows[i]);
      drain();
      write_nodes(8);
      send_request(edge_row(1, 2));
      send_request(edge_row(2, 1));
      send_request(edge_row(7, 8));
      drain();
      write_nodes(4);
      send_request(edge_row(3, 1));
      send_request(count_row(0, 1'b0, 1'b0));
      drain();

      // Store full: fill all edges, one more is dropped
      write_nodes(16);
      for (int k = 0; k < EMAX + 1; k++)
         send_request(edge_row($urandom_range(15), $urandom_range(15)));
      send_request(count_row(0, 1'b1, 1'b0));
      drain();

      // Long receiver hold-off while edges keep flowing and a count queues
      write_nodes(32);
      hold_receiver = 1'b1;
      random_case(20, 32);
      fork
         begin
            repeat (3000) @(posedge clock);
            hold_receiver = 1'b0;
         end
         random_case(10, 32);
      join
      drain();

      // Random phases with various node counts
      for (int ph = 0; ph < 4; ph++) begin
         send_idle_pct = phase_idle[ph];
         recv_stall_pct = phase_stall[ph];
         for (int c = 0; c < 8; c++) begin
            sz = ($urandom_range(9) == 0) ? $urandom_range(2, 1024) : $urandom_range(2, 24);
            write_nodes(sz);
            span = sz + 1;
            random_case($urandom_range(4, 2 * sz + 4 > 90 ? 90 : 2 * sz + 4), span);
            if ($urandom_range(1)) random_case($urandom_range(1, 30), span);
            drain();
         end
      end
      send_idle_pct = 0;
      recv_stall_pct = 0;

      while (pending_results.size() != 0) @(posedge clock);
      repeat (4 * NMAX + 50) @(posedge clock);
      $display("covered %0d edge items and %0d counts, %0d results checked",
               edges_sent, counts_sent, results_seen);
      if (errors == 0 && pending_results.size() == 0)
         $display("status: pass");
      else
         $display("status: fail");
      $finish;
   end

endmodule

`default_nettype wire

// ===== files.f =====
+incdir+sv
sv/scc_pkg.sv
sv/scc_if.sv
sv/scc_ctrl.sv
sv/scc_dpath.sv
sv/scc_counter_top.sv
tb/scc_tb_if.sv
tb/testbench.sv
